>>> hw/rtl/source_token_scanner_defines.svh
// Assertion macros used by the checker file of the token scanner.
`ifndef SOURCE_TOKEN_SCANNER_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define STS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token scanner check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token scanner sequence check failed");

`endif

>>> hw/rtl/sts_pkg.sv
// Types, constants and character codes of the source token scanner.
`default_nettype none

package sts_pkg;

    // Result field width on the output bus and default position counter width
    localparam int FIELD_BITS            = 24;
    localparam int POSITION_BITS_DEFAULT = 24;

    // Result queue geometry: a word yields up to three tokens
    localparam int RESULT_SLOTS = 3;
    localparam int FIFO_DEPTH   = 4;
    localparam int PTR_BITS     = $clog2(FIFO_DEPTH);
    localparam int COUNT_BITS   = $clog2(FIFO_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_INT   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_HALT  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_END   = 3'd0,
        KIND_PLUS  = 3'd1,
        KIND_MINUS = 3'd2,
        KIND_SEMI  = 3'd3,
        KIND_INT   = 3'd4,
        KIND_IDENT = 3'd5,
        KIND_ERROR = 3'd6
    } kind_t;

    typedef logic [PTR_BITS-1:0]   ptr_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        kind_t                 kind;
        logic [FIELD_BITS-1:0] start_offset;
        logic [FIELD_BITS-1:0] token_length;
        logic [FIELD_BITS-1:0] line_number;
        logic [FIELD_BITS-1:0] column_number;
        logic [7:0]            bad_byte;
        logic                  last_of_run;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/sts_lexer.sv
// Scanner state and per-word token decode, up to three tokens per word.
`default_nettype none

module sts_lexer #(
    parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             fire,
    input  wire logic [7:0]                       src_byte,
    input  wire logic                             fin,
    output sts_pkg::result_t                      items [sts_pkg::RESULT_SLOTS],
    output logic [sts_pkg::RESULT_SLOTS-1:0]      item_valid
);

    import sts_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    typedef logic [POSITION_BITS-1:0] pos_t;

    function automatic pos_t sat_inc(input pos_t v);
        return (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    function automatic pos_t column_of(input pos_t off, input pos_t lso);
        pos_t d;
        d = (off >= lso) ? off - lso : '0;
        return sat_inc(d);
    endfunction

    function automatic pos_t length_of(input pos_t stop, input pos_t start);
        return (stop >= start) ? stop - start : '0;
    endfunction

    mode_t mode_reg, mode_next, mode_mid;
    pos_t  off_reg, off_next;
    pos_t  rs_reg, rs_next, rs_mid;
    pos_t  line_reg, line_next, line_mid;
    pos_t  lso_reg, lso_next, lso_mid;
    pos_t  rl_reg, rl_next, rl_mid;
    pos_t  rc_reg, rc_next, rc_mid;

    logic  is_digit, is_ident_begin, is_space, is_lf;
    logic  run_open, run_cont;
    logic  flush1, single, flush2, end_tok;
    kind_t single_kind;
    pos_t  nxt, col_o;

    // Classify the byte
    assign is_digit       = (src_byte >= CHAR_ZERO) && (src_byte <= CHAR_NINE);
    assign is_ident_begin = ((src_byte >= CHAR_LO_A) && (src_byte <= CHAR_LO_Z))
                         || ((src_byte >= CHAR_UP_A) && (src_byte <= CHAR_UP_Z))
                         || (src_byte == CHAR_UNDER);
    assign is_lf          = (src_byte == CHAR_LF);
    assign is_space       = (src_byte == CHAR_SPACE) || (src_byte == CHAR_TAB)
                         || (src_byte == CHAR_CR) || is_lf
                         || (src_byte == CHAR_VT) || (src_byte == CHAR_FF);

    assign nxt      = sat_inc(off_reg);
    assign col_o    = column_of(off_reg, lso_reg);
    assign run_open = (mode_reg == MODE_INT) || (mode_reg == MODE_IDENT);
    assign run_cont = ((mode_reg == MODE_INT) && is_digit)
                   || ((mode_reg == MODE_IDENT) && (is_digit || is_ident_begin));

    // Next state: the effect of the byte, then the end-of-source reset
    always_comb
    begin
        mode_mid    = mode_reg;
        rs_mid      = rs_reg;
        line_mid    = line_reg;
        lso_mid     = lso_reg;
        rl_mid      = rl_reg;
        rc_mid      = rc_reg;
        flush1      = 1'b0;
        single      = 1'b0;
        single_kind = KIND_ERROR;
        if ((mode_reg != MODE_HALT) && !run_cont)
        begin
            flush1   = run_open;
            mode_mid = MODE_IDLE;
            if (is_space)
            begin
                if (is_lf)
                begin
                    line_mid = sat_inc(line_reg);
                    lso_mid  = nxt;
                end
            end
            else if (src_byte == CHAR_PLUS)
            begin
                single      = 1'b1;
                single_kind = KIND_PLUS;
            end
            else if (src_byte == CHAR_MINUS)
            begin
                single      = 1'b1;
                single_kind = KIND_MINUS;
            end
            else if (src_byte == CHAR_SEMI)
            begin
                single      = 1'b1;
                single_kind = KIND_SEMI;
            end
            else if (is_digit || is_ident_begin)
            begin
                mode_mid = is_digit ? MODE_INT : MODE_IDENT;
                rs_mid   = off_reg;
                rl_mid   = line_reg;
                rc_mid   = col_o;
            end
            else
            begin
                single      = 1'b1;
                single_kind = KIND_ERROR;
                mode_mid    = MODE_HALT;
            end
        end

        flush2  = fin && ((mode_mid == MODE_INT) || (mode_mid == MODE_IDENT));
        end_tok = fin && (mode_mid != MODE_HALT);

        if (fin)
        begin
            mode_next = MODE_IDLE;
            off_next  = '0;
            rs_next   = '0;
            line_next = POS_ONE;
            lso_next  = '0;
            rl_next   = POS_ONE;
            rc_next   = POS_ONE;
        end
        else
        begin
            mode_next = mode_mid;
            off_next  = (mode_reg == MODE_HALT) ? off_reg : nxt;
            rs_next   = rs_mid;
            line_next = line_mid;
            lso_next  = lso_mid;
            rl_next   = rl_mid;
            rc_next   = rc_mid;
        end
    end

    // Token slots: closed run, single token or flushed run, end token
    always_comb
    begin
        items[0].kind          = (mode_reg == MODE_INT) ? KIND_INT : KIND_IDENT;
        items[0].start_offset  = FIELD_BITS'(rs_reg);
        items[0].token_length  = FIELD_BITS'(length_of(off_reg, rs_reg));
        items[0].line_number   = FIELD_BITS'(rl_reg);
        items[0].column_number = FIELD_BITS'(rc_reg);
        items[0].bad_byte      = '0;

        if (single)
        begin
            items[1].kind          = single_kind;
            items[1].start_offset  = FIELD_BITS'(off_reg);
            items[1].token_length  = FIELD_BITS'(1);
            items[1].line_number   = FIELD_BITS'(line_reg);
            items[1].column_number = FIELD_BITS'(col_o);
            items[1].bad_byte      = (single_kind == KIND_ERROR) ? src_byte : 8'h00;
        end
        else
        begin
            items[1].kind          = (mode_mid == MODE_INT) ? KIND_INT : KIND_IDENT;
            items[1].start_offset  = FIELD_BITS'(rs_mid);
            items[1].token_length  = FIELD_BITS'(length_of(nxt, rs_mid));
            items[1].line_number   = FIELD_BITS'(rl_mid);
            items[1].column_number = FIELD_BITS'(rc_mid);
            items[1].bad_byte      = '0;
        end

        items[2].kind          = KIND_END;
        items[2].start_offset  = FIELD_BITS'(nxt);
        items[2].token_length  = '0;
        items[2].line_number   = FIELD_BITS'(line_mid);
        items[2].column_number = FIELD_BITS'(column_of(nxt, lso_mid));
        items[2].bad_byte      = '0;

        item_valid = {end_tok, single || flush2, flush1};

        // Mark the last token this word yields
        items[0].last_of_run = item_valid[0] && !item_valid[1] && !item_valid[2];
        items[1].last_of_run = item_valid[1] && !item_valid[2];
        items[2].last_of_run = item_valid[2];
    end

    // Advance scanner state on each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            off_reg  <= '0;
            rs_reg   <= '0;
            line_reg <= POS_ONE;
            lso_reg  <= '0;
            rl_reg   <= POS_ONE;
            rc_reg   <= POS_ONE;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            off_reg  <= off_next;
            rs_reg   <= rs_next;
            line_reg <= line_next;
            lso_reg  <= lso_next;
            rl_reg   <= rl_next;
            rc_reg   <= rc_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sts_result_fifo.sv
// Result queue that takes up to three tokens at once and sends one per ready cycle.
`default_nettype none

module sts_result_fifo (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  sts_pkg::result_t                   wr_items [sts_pkg::RESULT_SLOTS],
    input  wire logic [sts_pkg::RESULT_SLOTS-1:0] wr_valid,
    output logic                               room,
    output logic                               rd_valid,
    input  wire logic                          rd_ready,
    output sts_pkg::result_t                   rd_item
);

    import sts_pkg::*;

    result_t entries_reg [FIFO_DEPTH];
    ptr_t    wptr_reg, wptr_next;
    ptr_t    rptr_reg, rptr_next;
    count_t  count_reg, count_next;
    ptr_t    slot_ofs [RESULT_SLOTS];
    count_t  n_wr;
    logic    rd_fire;

    // Room for a full set of tokens from one word
    assign room     = (count_reg <= COUNT_BITS'(FIFO_DEPTH - RESULT_SLOTS));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entries_reg[rptr_reg];
    assign rd_fire  = rd_valid && rd_ready;

    // Pack the valid slots in order behind the write pointer
    always_comb
    begin
        n_wr = '0;
        for (int k = 0; k < RESULT_SLOTS; k++)
        begin
            slot_ofs[k] = PTR_BITS'(n_wr);
            if (wr_en && wr_valid[k])
            begin
                n_wr = n_wr + COUNT_BITS'(1);
            end
        end
        wptr_next  = wptr_reg + PTR_BITS'(n_wr);
        rptr_next  = rd_fire ? rptr_reg + PTR_BITS'(1) : rptr_reg;
        count_next = count_reg + n_wr - (rd_fire ? COUNT_BITS'(1) : COUNT_BITS'(0));
    end

    // Store incoming tokens
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RESULT_SLOTS; k++)
        begin
            if (wr_en && wr_valid[k])
            begin
                entries_reg[wptr_reg + slot_ofs[k]] <= wr_items[k];
            end
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/source_token_scanner.sv
// Top level of the source token scanner: input register, lexer and result queue.
//
// Usage:
//   Source bytes enter on the s_axis channel, one byte per word, with tlast
//   on the final byte of a source. Tokens leave on the m_axis channel, one
//   token per word: tuser carries the kind, tdata the position fields, and
//   tlast marks the last token caused by one input byte.
//   The byte is decoded from the input register into the result queue once
//   the queue has room, and its tokens leave m_axis in order behind older ones.
//   Throughput: one byte per cycle while bytes yield at most one token each and
//   m_axis_tready stays high. The m_axis side drains one token per cycle while
//   m_axis_tready is high, from a four-entry queue, and a byte is decoded only
//   when the queue has room for three tokens, so bytes that close a run and
//   also give a token or end the source stall later bytes until it drains.
//   Reset empties the input register and the queue and sets the scanner to
//   offset 0, line 1, column 1. The final byte also returns it there.
//   When the receiver stalls, tokens wait in the queue; once fewer than three
//   entries are free the input register holds its byte and s_axis_tready drops.
`default_nettype none

module source_token_scanner #(
    parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] source_byte
    input  wire logic         s_axis_tlast,   // final_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata,   // start_offset, token_length,
                                              // line_number, column_number, bad_byte
    output logic [2:0]        m_axis_tuser,   // token_kind
    output logic              m_axis_tlast    // last_of_run
);

    import sts_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_fin_reg;
    logic       fire;
    logic       room;
    result_t    tok_items [RESULT_SLOTS];
    logic [RESULT_SLOTS-1:0] tok_valid;
    result_t    out_item;

    // Decode the held byte when the queue can take its tokens
    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;

    // Hold the accepted word for decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_fin_reg  <= s_axis_tlast;
        end
    end

    sts_lexer #(
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .src_byte   (in_byte_reg),
        .fin        (in_fin_reg),
        .items      (tok_items),
        .item_valid (tok_valid)
    );

    sts_result_fifo u_result_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fire),
        .wr_items (tok_items),
        .wr_valid (tok_valid),
        .room     (room),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_item  (out_item)
    );

    // Pack the token word
    assign m_axis_tdata = {out_item.bad_byte, out_item.column_number, out_item.line_number,
                           out_item.token_length, out_item.start_offset};
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.last_of_run;

endmodule

`default_nettype wire

>>> hw/rtl/sts_checker.sv
// Port-level checks of the source token scanner and their bind to the top level.
`default_nettype none

`include "source_token_scanner_defines.svh"

module sts_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [103:0] m_axis_tdata,
    input  wire logic [2:0]   m_axis_tuser,
    input  wire logic         m_axis_tlast
);

    import sts_pkg::*;

    logic         out_end, out_single, out_error;
    logic         end_ok, len_one, no_bad, pos_ok, out_stall;
    logic [107:0] out_word;

    assign out_end    = m_axis_tvalid && (m_axis_tuser == KIND_END);
    assign out_error  = m_axis_tvalid && (m_axis_tuser == KIND_ERROR);
    assign out_single = m_axis_tvalid && ((m_axis_tuser == KIND_PLUS)
                     || (m_axis_tuser == KIND_MINUS) || (m_axis_tuser == KIND_SEMI)
                     || (m_axis_tuser == KIND_ERROR));

    // Field tests on the token word
    assign end_ok    = (m_axis_tdata[47:24] == 24'd0) && m_axis_tlast;
    assign len_one   = (m_axis_tdata[47:24] == 24'd1);
    assign no_bad    = (m_axis_tdata[103:96] == 8'd0);
    assign pos_ok    = (m_axis_tdata[71:48] != 24'd0) && (m_axis_tdata[95:72] != 24'd0);
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // End token has zero length and closes the tokens of its byte
    `STS_ASSERT_IMPLY(a_end_token, clk, rst_n, out_end, end_ok)

    // Operator and error tokens span one byte
    `STS_ASSERT_IMPLY(a_single_len, clk, rst_n, out_single, len_one)

    // Offending byte shows only on error tokens
    `STS_ASSERT_IMPLY(a_bad_byte, clk, rst_n, m_axis_tvalid && !out_error, no_bad)

    // Lines and columns count from one
    `STS_ASSERT_IMPLY(a_pos_base, clk, rst_n, m_axis_tvalid, pos_ok)

    // A stalled token word holds
    `STS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))

endmodule

bind source_token_scanner sts_checker u_sts_checker (.*);

`default_nettype wire

>>> tb/token_stream_checker.sv
`timescale 1ns / 1ps
// Token stream checker: predicts scanner tokens from accepted bytes and compares them.
module token_stream_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    input  logic [2:0]   m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending_tokens,
    output int           scanned_bytes,
    output int           tokens_checked,
    output int           error_tokens
);

    import sts_pkg::*;

    localparam logic [FIELD_BITS-1:0] POS_MAX = '1;

    // Scanner state as the predictor sees it
    mode_t                 mode;
    logic [FIELD_BITS-1:0] offset;
    logic [FIELD_BITS-1:0] run_start;
    logic [FIELD_BITS-1:0] cur_line;
    logic [FIELD_BITS-1:0] line_start;
    logic [FIELD_BITS-1:0] run_line;
    logic [FIELD_BITS-1:0] run_col;

    // Tokens predicted but not yet seen on the output
    result_t expected_tokens[$];

    function automatic logic [FIELD_BITS-1:0] bump(input logic [FIELD_BITS-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + 1'b1;
    endfunction

    function automatic logic [FIELD_BITS-1:0] column_at(input logic [FIELD_BITS-1:0] off);
        return bump((off >= line_start) ? off - line_start : '0);
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    function automatic bit is_name_start(input logic [7:0] b);
        return ((b >= CHAR_LO_A) && (b <= CHAR_LO_Z)) ||
               ((b >= CHAR_UP_A) && (b <= CHAR_UP_Z)) || (b == CHAR_UNDER);
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF, CHAR_VT, CHAR_FF};
    endfunction

    function automatic result_t make_token(input kind_t k,
                                           input logic [FIELD_BITS-1:0] start,
                                           input logic [FIELD_BITS-1:0] len,
                                           input logic [FIELD_BITS-1:0] line_no,
                                           input logic [FIELD_BITS-1:0] col,
                                           input logic [7:0] bad);
        result_t t;
        t.kind          = k;
        t.start_offset  = start;
        t.token_length  = len;
        t.line_number   = line_no;
        t.column_number = col;
        t.bad_byte      = bad;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    // Close the open integer or identifier run at end_off
    function automatic result_t close_run(input logic [FIELD_BITS-1:0] end_off);
        result_t t;
        t = make_token((mode == MODE_INT) ? KIND_INT : KIND_IDENT, run_start,
                       (end_off >= run_start) ? end_off - run_start : '0,
                       run_line, run_col, 8'h00);
        mode = MODE_IDLE;
        return t;
    endfunction

    function automatic void clear_scanner();
        mode       = MODE_IDLE;
        offset     = '0;
        run_start  = '0;
        cur_line   = FIELD_BITS'(1);
        line_start = '0;
        run_line   = FIELD_BITS'(1);
        run_col    = FIELD_BITS'(1);
    endfunction

    // Advance the scanner by one byte and queue the tokens it gives
    task automatic scan_byte(input logic [7:0] b, input logic fin);
        result_t               found[RESULT_SLOTS];
        logic [FIELD_BITS-1:0] here;
        logic [FIELD_BITS-1:0] nxt;
        logic [FIELD_BITS-1:0] one;
        int                    n;
        n    = 0;
        one  = FIELD_BITS'(1);
        here = offset;
        nxt  = bump(offset);
        if (mode == MODE_HALT)
        begin
            // halted after an error: drop bytes until the source ends
            if (fin)
                clear_scanner();
        end
        else
        begin
            scanned_bytes++;
            if (!((mode == MODE_INT && is_digit(b)) ||
                  (mode == MODE_IDENT && (is_name_start(b) || is_digit(b)))))
            begin
                if (mode != MODE_IDLE)
                begin
                    found[n] = close_run(here);
                    n++;
                end
                if (is_blank(b))
                begin
                    if (b == CHAR_LF)
                    begin
                        cur_line   = bump(cur_line);
                        line_start = nxt;
                    end
                end
                else if (b == CHAR_PLUS)
                begin
                    found[n] = make_token(KIND_PLUS, here, one, cur_line, column_at(here), 8'h00);
                    n++;
                end
                else if (b == CHAR_MINUS)
                begin
                    found[n] = make_token(KIND_MINUS, here, one, cur_line, column_at(here), 8'h00);
                    n++;
                end
                else if (b == CHAR_SEMI)
                begin
                    found[n] = make_token(KIND_SEMI, here, one, cur_line, column_at(here), 8'h00);
                    n++;
                end
                else if (is_digit(b) || is_name_start(b))
                begin
                    mode      = is_digit(b) ? MODE_INT : MODE_IDENT;
                    run_start = here;
                    run_line  = cur_line;
                    run_col   = column_at(here);
                end
                else
                begin
                    found[n] = make_token(KIND_ERROR, here, one, cur_line, column_at(here), b);
                    n++;
                    mode = MODE_HALT;
                end
            end
            offset = nxt;
            // flush the run and close the source on its final byte
            if (fin)
            begin
                if (mode == MODE_INT || mode == MODE_IDENT)
                begin
                    found[n] = close_run(nxt);
                    n++;
                end
                if (mode != MODE_HALT)
                begin
                    found[n] = make_token(KIND_END, nxt, '0, cur_line, column_at(nxt), 8'h00);
                    n++;
                end
                clear_scanner();
            end
            if (n > 0)
                found[n-1].last_of_run = 1'b1;
            for (int i = 0; i < n; i++)
                expected_tokens.push_back(found[i]);
        end
    endtask

    function automatic void check_field(input string name,
                                        input logic [FIELD_BITS-1:0] want,
                                        input logic [FIELD_BITS-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare one output word with the oldest predicted token
    task automatic check_token();
        result_t want;
        tokens_checked++;
        if (expected_tokens.size() == 0)
        begin
            $error("unexpected token: kind %0d at offset %0d", m_axis_tuser,
                   m_axis_tdata[23:0]);
            fail_count++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (want.kind == KIND_ERROR)
                error_tokens++;
            check_field("token_kind", FIELD_BITS'(want.kind), FIELD_BITS'(m_axis_tuser));
            check_field("start_offset",  want.start_offset,  m_axis_tdata[23:0]);
            check_field("token_length",  want.token_length,  m_axis_tdata[47:24]);
            check_field("line_number",   want.line_number,   m_axis_tdata[71:48]);
            check_field("column_number", want.column_number, m_axis_tdata[95:72]);
            check_field("bad_byte", FIELD_BITS'(want.bad_byte),
                        FIELD_BITS'(m_axis_tdata[103:96]));
            check_field("last_of_run", FIELD_BITS'(want.last_of_run),
                        FIELD_BITS'(m_axis_tlast));
        end
    endtask

    // Watch both channels; check outputs before predicting from the new byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scanner();
            expected_tokens.delete();
            fail_count     = 0;
            scanned_bytes  = 0;
            tokens_checked = 0;
            error_tokens   = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_token();
            if (s_axis_tvalid && s_axis_tready)
                scan_byte(s_axis_tdata, s_axis_tlast);
        end
        pending_tokens = expected_tokens.size();
    end

endmodule

>>> tb/source_token_scanner_tb.sv
`timescale 1ns / 1ps
// Testbench top of the source token scanner: clock, reset, byte stimulus and verdict.
module source_token_scanner_tb;
    import sts_pkg::*;

    localparam int RANDOM_BYTES   = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'h00;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    int fail_count;
    int pending_tokens;
    int scanned_bytes;
    int tokens_checked;
    int error_tokens;

    logic [7:0] source_q[$];
    bit         tx_quiet     = 1'b0;
    int         sources_sent = 0;
    int         idle_cycles  = 0;
    int         rx_hold      = 0;
    int         rx_calm      = 0;
    int         rx_roll;

    source_token_scanner i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    token_stream_checker i_token_check (.*);

    always #5 clk = ~clk;

    // Stall the receiver at random, with stall-free stretches in between
    always @(negedge clk)
    begin
        if (rx_calm > 0)
        begin
            rx_calm--;
            m_axis_tready <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 3)
                rx_calm = $urandom_range(20, 80);
            else if (rx_roll < 25)
                rx_hold = $urandom_range(1, 3);
            else if (rx_roll < 29)
                rx_hold = $urandom_range(10, 30);
            m_axis_tready <= (rx_hold == 0);
        end
    end

    // End the run when no word moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] name_byte(input bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26)
            return 8'(CHAR_LO_A + r);
        else if (r < 52)
            return 8'(CHAR_UP_A + (r - 26));
        else if (r == 52)
            return CHAR_UNDER;
        else
            return 8'(CHAR_ZERO + (r - 53));
    endfunction

    // Offer one byte and hold it until the scanner takes it
    task automatic send_word(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Send the collected source, tlast on its final byte
    task automatic send_source();
        for (int i = 0; i < source_q.size(); i++)
            send_word(source_q[i], i == source_q.size() - 1);
        source_q.delete();
        sources_sent++;
    endtask

    // Hold the sender until every predicted token has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_tokens != 0);
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            source_q.push_back(s[i]);
    endfunction

    // Build a source: mostly well-formed tokens, sometimes raw noise or an error
    task automatic build_random_source();
        string      marks;
        logic [7:0] b;
        marks = "!\"#$%&'()*,./:<=>?@[\\]^{|}~";
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 12))
                source_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 10))
            begin
                case ($urandom_range(0, 9)) inside
                    [0:2]:
                    begin
                        source_q.push_back(name_byte(1'b1));
                        repeat ($urandom_range(0, 5))
                            source_q.push_back(name_byte(1'b0));
                    end
                    [3:4]:
                        repeat ($urandom_range(1, 5))
                            source_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                    [5:6]:
                        case ($urandom_range(0, 2))
                            0:       source_q.push_back(CHAR_PLUS);
                            1:       source_q.push_back(CHAR_MINUS);
                            default: source_q.push_back(CHAR_SEMI);
                        endcase
                    default:
                        case ($urandom_range(0, 6)) inside
                            [0:1]:   source_q.push_back(CHAR_LF);
                            2:       source_q.push_back(CHAR_SPACE);
                            3:       source_q.push_back(CHAR_TAB);
                            4:       source_q.push_back(CHAR_CR);
                            5:       source_q.push_back(CHAR_VT);
                            default: source_q.push_back(CHAR_FF);
                        endcase
                endcase
            end
            // unsupported byte, then bytes the halted scanner drops
            if ($urandom_range(0, 6) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       b = 8'($urandom_range(8'h80, 8'hFF));
                    1:       b = 8'($urandom_range(8'h00, 8'h08));
                    2:       b = 8'($urandom_range(8'h0E, 8'h1F));
                    default: b = marks[$urandom_range(0, marks.len() - 1)];
                endcase
                source_q.push_back(b);
                repeat ($urandom_range(0, 4))
                    source_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        int base;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every non-error class of byte; final '+' closes a run and gives three tokens
        push_text("_aZ9 +-;");
        source_q.push_back(CHAR_LF);
        source_q.push_back(CHAR_CR);
        source_q.push_back(CHAR_VT);
        source_q.push_back(CHAR_FF);
        source_q.push_back(CHAR_TAB);
        push_text("09A z+");
        send_source();
        // final newline: end token on the next line
        push_text("7");
        source_q.push_back(CHAR_LF);
        send_source();
        // error closes a run, then halted bytes and a silent final byte
        push_text("q");
        source_q.push_back(8'hFF);
        push_text("ab");
        source_q.push_back(8'h00);
        send_source();
        // error on the final byte, then a source of blank only
        source_q.push_back(8'h00);
        send_source();
        source_q.push_back(CHAR_SPACE);
        send_source();
        wait_drained();

        // random sources until enough live bytes went through
        base = scanned_bytes;
        while (scanned_bytes - base < RANDOM_BYTES)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            build_random_source();
            send_source();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Scanned %0d bytes in %0d sources; checked %0d tokens, %0d of them errors.",
                 scanned_bytes, sources_sent, tokens_checked, error_tokens);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
